// ----- design/mrl_pkg.sv -----
`default_nettype none

package mrl_pkg;

  // default depth of the lookup table
  localparam int TABLE_DEPTH_DEF = 4096;

  // register file layout
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_TYPE,
    CFG_LITTLE_ENDIAN,
    CFG_USE_TABLE,
    CFG_SLOPE,
    CFG_INTERCEPT,
    CFG_MAP_BASE,
    CFG_LAST_ENTRY
  } cfg_index_t;

  // raw sample encodings
  typedef enum logic [2:0] {
    ST_U8,
    ST_S8,
    ST_U16,
    ST_S16,
    ST_U32,
    ST_S32,
    ST_F32,
    ST_F64
  } sample_type_t;

  // transaction operation codes
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  // binary64 constants
  localparam logic [63:0] SLOPE_RESET = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

  // exponent width of the scaled integer form (value = mag * 2^exp)
  localparam int XEXP_W = 14;

  // sample operand handed to the multiplier
  typedef struct packed {
    logic                       sign;
    logic [52:0]                mag;
    logic signed [XEXP_W-1:0]   exp;
    logic                       spec;
    logic [63:0]                word;
  } dbl_op_t;

endpackage

`default_nettype wire

// ----- design/modality_rescale_or_lut_unit.sv -----
`default_nettype none

// Modality conversion of raw monochrome samples to binary32.
// Input channel (in_valid/in_ready): operation selects a sample conversion
// or a table word load (entry_index, entry_word). A load gives no result.
// Output channel (out_valid/out_ready): value_bits and type_error, one
// transaction per converted sample, in input order.
// Configuration: cfg_write with cfg_index and cfg_data writes one register;
// write only while the block is empty.
// Throughput is one item per cycle unless a stall holds the pipeline; the
// pipeline is set by the binary64 multiply (two stages), three rounding
// units (four stages each) and a three stage adder.
// The lookup table is one synchronous RAM, read and written in the second
// stage so loads and lookups keep their order.
// Reset clears all pipeline valid flags and puts the registers at their
// defaults: u16 little endian, rescale mode, slope 1.0, intercept 0,
// first mapped value 0, last entry 4095. Table contents are undefined
// until loaded. When out_ready is low and the last stage is occupied, the
// whole pipeline holds and in_ready drops.
module modality_rescale_or_lut_unit #(
  parameter int TABLE_DEPTH = mrl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              operation,
  input  wire logic [63:0]                       sample_bytes,
  input  wire logic [11:0]                       entry_index,
  input  wire logic [31:0]                       entry_word,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [31:0]                            value_bits,
  output logic                                   type_error,
  input  wire logic                              cfg_write,
  input  wire logic [mrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mrl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import mrl_pkg::*;

  localparam int LAST = 18;
  localparam int LUT_DLY = 16;

  // configuration registers
  sample_type_t cfg_sample_type;
  logic         cfg_little_endian, cfg_use_table;
  logic [63:0]  cfg_slope, cfg_intercept;
  logic [31:0]  cfg_map_base;
  logic [11:0]  cfg_last_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_sample_type   <= ST_U16;
      cfg_little_endian <= 1'b1;
      cfg_use_table     <= 1'b0;
      cfg_slope         <= SLOPE_RESET;
      cfg_intercept     <= '0;
      cfg_map_base      <= '0;
      cfg_last_entry    <= 12'hFFF;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SAMPLE_TYPE:   cfg_sample_type   <= sample_type_t'(cfg_data[2:0]);
        CFG_LITTLE_ENDIAN: cfg_little_endian <= cfg_data[0];
        CFG_USE_TABLE:     cfg_use_table     <= cfg_data[0];
        CFG_SLOPE:         cfg_slope         <= cfg_data;
        CFG_INTERCEPT:     cfg_intercept     <= cfg_data;
        CFG_MAP_BASE:      cfg_map_base      <= cfg_data[31:0];
        CFG_LAST_ENTRY:    cfg_last_entry    <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline advance and valid flags
  logic            adv;
  logic [LAST:0]   vld;
  logic            s0_op, s1_op;
  logic [63:0]     s0_bytes;
  logic [11:0]     s0_index, s1_index;
  logic [31:0]     s0_word, s1_word;

  assign adv      = !vld[LAST] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld[0] <= in_valid;
      vld[1] <= vld[0];
      vld[2] <= vld[1] && (s1_op == OP_CONVERT);
      for (int k = 3; k <= LAST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op    <= operation;
      s0_bytes <= sample_bytes;
      s0_index <= entry_index;
      s0_word  <= entry_word;
    end
  end

  // sample extraction and decode
  logic [63:0]        raw, b;
  logic signed [32:0] ival, aval;
  logic [7:0]         f32e;
  logic [10:0]        f64e;
  dbl_op_t            xop;

  always_comb begin
    b = s0_bytes;
    unique case (cfg_sample_type) inside
      ST_U8, ST_S8: begin
        raw = {56'd0, b[7:0]};
      end
      ST_U16, ST_S16: begin
        raw = cfg_little_endian ? {48'd0, b[15:0]} : {48'd0, b[7:0], b[15:8]};
      end
      ST_U32, ST_S32, ST_F32: begin
        raw = cfg_little_endian ? {32'd0, b[31:0]}
                                : {32'd0, b[7:0], b[15:8], b[23:16], b[31:24]};
      end
      default: begin
        raw = cfg_little_endian ? b
                                : {b[7:0], b[15:8], b[23:16], b[31:24],
                                   b[39:32], b[47:40], b[55:48], b[63:56]};
      end
    endcase

    unique case (cfg_sample_type)
      ST_U8:   ival = {25'd0, raw[7:0]};
      ST_S8:   ival = {{25{raw[7]}}, raw[7:0]};
      ST_U16:  ival = {17'd0, raw[15:0]};
      ST_S16:  ival = {{17{raw[15]}}, raw[15:0]};
      ST_U32:  ival = {1'b0, raw[31:0]};
      ST_S32:  ival = {raw[31], raw[31:0]};
      default: ival = '0;
    endcase

    aval = ival[32] ? -ival : ival;
    f32e = raw[30:23];
    f64e = raw[62:52];
    xop  = '0;
    unique case (cfg_sample_type) inside
      ST_F32: begin
        xop.sign = raw[31];
        if (f32e == 8'hFF) begin
          xop.spec = 1'b1;
          xop.word = (raw[22:0] == '0) ? {raw[31], 11'h7FF, 52'd0}
                                       : {raw[31], 11'h7FF, 1'b1, raw[21:0], 29'd0};
        end else begin
          xop.mag = {29'd0, f32e != '0, raw[22:0]};
          xop.exp = (f32e == '0) ? -14'sd149 : $signed({6'd0, f32e}) - 14'sd150;
        end
      end
      ST_F64: begin
        xop.sign = raw[63];
        if (f64e == 11'h7FF) begin
          xop.spec = 1'b1;
          xop.word = (raw[51:0] == '0) ? raw : (raw | QUIET_BIT);
        end else begin
          xop.mag = {f64e != '0, raw[51:0]};
          xop.exp = (f64e == '0) ? -14'sd1074 : $signed({3'd0, f64e}) - 14'sd1075;
        end
      end
      default: begin
        xop.sign = ival[32];
        xop.mag  = {20'd0, aval[32:0]};
      end
    endcase
  end

  // decoded stage
  dbl_op_t            s1_x;
  logic signed [32:0] s1_ival;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op    <= s0_op;
      s1_x     <= xop;
      s1_ival  <= ival;
      s1_index <= s0_index;
      s1_word  <= s0_word;
    end
  end

  // lookup table
  logic [31:0] lut_q;
  logic [31:0] lut_dly [LUT_DLY];

  mrl_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk          (clk),
    .en           (adv),
    .wr_en        (adv && vld[1] && (s1_op == OP_LOAD)),
    .wr_index     (s1_index),
    .wr_word      (s1_word),
    .sample_val   (s1_ival),
    .map_base     (cfg_map_base),
    .last_entry   (cfg_last_entry),
    .rd_word      (lut_q)
  );

  // table word follows the rescale pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      lut_dly[0] <= lut_q;
      for (int k = 1; k < LUT_DLY; k++) begin
        lut_dly[k] <= lut_dly[k-1];
      end
    end
  end

  // sample times slope
  logic                     m_sign, m_spec;
  logic [105:0]             m_mag;
  logic signed [XEXP_W-1:0] m_exp;
  logic [63:0]              m_word, prod;

  mrl_fmul u_fmul (
    .clk        (clk),
    .en         (adv),
    .x          (s1_x),
    .slope_bits (cfg_slope),
    .out_sign   (m_sign),
    .out_mag    (m_mag),
    .out_exp    (m_exp),
    .out_spec   (m_spec),
    .out_word   (m_word)
  );

  mrl_round #(
    .W (106), .MB (53), .EW (11), .BIAS (1023), .EXW (XEXP_W)
  ) u_round_prod (
    .clk      (clk),
    .en       (adv),
    .in_sign  (m_sign),
    .in_mag   (m_mag),
    .in_exp   (m_exp),
    .in_spec  (m_spec),
    .in_word  (m_word),
    .out_word (prod)
  );

  // product plus intercept
  logic                     a_sign, a_spec;
  logic [56:0]              a_mag;
  logic signed [XEXP_W-1:0] a_exp;
  logic [63:0]              a_word, sum;

  mrl_fadd u_fadd (
    .clk      (clk),
    .en       (adv),
    .p_word   (prod),
    .c_word   (cfg_intercept),
    .out_sign (a_sign),
    .out_mag  (a_mag),
    .out_exp  (a_exp),
    .out_spec (a_spec),
    .out_word (a_word)
  );

  mrl_round #(
    .W (57), .MB (53), .EW (11), .BIAS (1023), .EXW (XEXP_W)
  ) u_round_sum (
    .clk      (clk),
    .en       (adv),
    .in_sign  (a_sign),
    .in_mag   (a_mag),
    .in_exp   (a_exp),
    .in_spec  (a_spec),
    .in_word  (a_word),
    .out_word (sum)
  );

  // binary64 to binary32
  logic [10:0]              se;
  logic                     f_spec;
  logic [52:0]              f_mag;
  logic signed [XEXP_W-1:0] f_exp;
  logic [31:0]              f_word, single;

  always_comb begin
    se     = sum[62:52];
    f_spec = (se == 11'h7FF);
    f_word = (sum[51:0] == '0) ? {sum[63], 8'hFF, 23'd0}
                               : {sum[63], 8'hFF, 1'b1, sum[50:29]};
    f_mag  = {se != '0, sum[51:0]};
    f_exp  = (se == '0) ? -14'sd1074 : $signed({3'd0, se}) - 14'sd1075;
  end

  mrl_round #(
    .W (53), .MB (24), .EW (8), .BIAS (127), .EXW (XEXP_W)
  ) u_round_single (
    .clk      (clk),
    .en       (adv),
    .in_sign  (sum[63]),
    .in_mag   (f_mag),
    .in_exp   (f_exp),
    .in_spec  (f_spec),
    .in_word  (f_word),
    .out_word (single)
  );

  // result select
  logic is_float;

  assign is_float   = (cfg_sample_type == ST_F32) || (cfg_sample_type == ST_F64);
  assign out_valid  = vld[LAST];
  assign type_error = cfg_use_table && is_float;
  assign value_bits = !cfg_use_table ? single
                    : (is_float ? 32'd0 : lut_dly[LUT_DLY-1]);

endmodule

`default_nettype wire

// ----- design/mrl_round.sv -----
`default_nettype none

module mrl_round #(
  parameter int W    = 106,
  parameter int MB   = 53,
  parameter int EW   = 11,
  parameter int BIAS = 1023,
  parameter int EXW  = 14
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic                   in_sign,
  input  wire logic [W-1:0]           in_mag,
  input  wire logic signed [EXW-1:0]  in_exp,
  input  wire logic                   in_spec,
  input  wire logic [EW+MB-1:0]       in_word,
  output logic      [EW+MB-1:0]       out_word
);

  localparam int IW  = 16;
  localparam int LZW = $clog2(W + 1);
  localparam int RW  = $clog2(W + 2);
  localparam int LW  = $clog2(MB + 1);
  localparam int FW  = EW + MB - 1;

  localparam logic signed [IW-1:0] WM1    = IW'(W - 1);
  localparam logic signed [IW-1:0] MBM1   = IW'(MB - 1);
  localparam logic signed [IW-1:0] EMIN_S = IW'(2 - BIAS - MB);
  localparam logic signed [IW-1:0] BIAS_S = IW'(BIAS);
  localparam logic signed [IW-1:0] BE_OFF = IW'(MB + BIAS - 2);
  localparam logic signed [IW-1:0] RMAX_S = IW'(W + 1);

  // stage a: leading zero count
  logic [LZW-1:0] lz;
  logic           a_sign, a_zero, a_spec;
  logic [W-1:0]   a_mag;
  logic signed [IW-1:0] a_exp;
  logic [LZW-1:0] a_lz;
  logic [FW:0]    a_word;

  always_comb begin
    lz = LZW'(W);
    for (int i = 0; i < W; i++) begin
      if (in_mag[i]) begin
        lz = LZW'(W - 1 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sign <= in_sign;
      a_mag  <= in_mag;
      a_exp  <= IW'(in_exp);
      a_lz   <= lz;
      a_zero <= (in_mag == '0);
      a_spec <= in_spec;
      a_word <= in_word;
    end
  end

  // stage b: target lsb weight, shift amounts, overflow
  logic signed [IW-1:0] lz_s, top, lsb_n, lsbw, dd, be_full;
  logic [RW-1:0] rsh;
  logic [LW-1:0] lsh;
  logic          b_sign, b_zero, b_spec, b_ovf;
  logic [W-1:0]  b_mag;
  logic [RW-1:0] b_rsh;
  logic [LW-1:0] b_lsh;
  logic [EW-1:0] b_be;
  logic [FW:0]   b_word;

  always_comb begin
    lz_s    = IW'(a_lz);
    top     = a_exp + WM1 - lz_s;
    lsb_n   = top - MBM1;
    lsbw    = (lsb_n < EMIN_S) ? EMIN_S : lsb_n;
    dd      = lsbw - a_exp;
    be_full = lsbw + BE_OFF;
    if (dd > RMAX_S) begin
      rsh = RW'(W + 1);
    end else if (dd > 0) begin
      rsh = dd[RW-1:0];
    end else begin
      rsh = '0;
    end
    lsh = (dd < 0) ? LW'(-dd) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sign <= a_sign;
      b_zero <= a_zero;
      b_spec <= a_spec;
      b_word <= a_word;
      b_mag  <= a_mag;
      b_rsh  <= rsh;
      b_lsh  <= lsh;
      b_be   <= be_full[EW-1:0];
      b_ovf  <= (top > BIAS_S);
    end
  end

  // stage c: align to the kept bits, collect guard and sticky
  logic [2*W-1:0] ext;
  logic [W-1:0]   kept_l;
  logic [MB-1:0]  mant;
  logic           c_sign, c_zero, c_spec, c_ovf, c_guard, c_sticky;
  logic [MB-1:0]  c_mant;
  logic [EW-1:0]  c_be;
  logic [FW:0]    c_word;

  always_comb begin
    ext    = {b_mag, {W{1'b0}}} >> b_rsh;
    kept_l = b_mag << b_lsh;
    mant   = (b_lsh != '0) ? kept_l[MB-1:0] : ext[W+MB-1:W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sign   <= b_sign;
      c_zero   <= b_zero;
      c_spec   <= b_spec;
      c_ovf    <= b_ovf;
      c_word   <= b_word;
      c_be     <= b_be;
      c_mant   <= mant;
      c_guard  <= ext[W-1];
      c_sticky <= |ext[W-2:0];
    end
  end

  // stage d: round to nearest even and pack
  logic          inc;
  logic [FW-1:0] rounded;

  always_comb begin
    inc     = c_guard & (c_sticky | c_mant[0]);
    rounded = {c_be, {(MB-1){1'b0}}} + FW'(c_mant) + FW'(inc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (c_spec) begin
        out_word <= c_word;
      end else if (c_zero) begin
        out_word <= {c_sign, {FW{1'b0}}};
      end else if (c_ovf) begin
        out_word <= {c_sign, {EW{1'b1}}, {(MB-1){1'b0}}};
      end else begin
        out_word <= {c_sign, rounded};
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/mrl_fmul.sv -----
`default_nettype none

module mrl_fmul (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire mrl_pkg::dbl_op_t                  x,
  input  wire logic [63:0]                       slope_bits,
  output logic                                   out_sign,
  output logic [105:0]                           out_mag,
  output logic signed [mrl_pkg::XEXP_W-1:0]      out_exp,
  output logic                                   out_spec,
  output logic [63:0]                            out_word
);

  import mrl_pkg::*;

  // stage 1: slope decode, special operands, partial products
  logic [10:0] se;
  logic [51:0] sf;
  logic        s_nan, s_inf, s_zero, x_nan, x_inf, x_zero, psign;
  logic [52:0] s_mag;
  logic signed [XEXP_W-1:0] s_exp;
  logic        spec;
  logic [63:0] word;

  logic [53:0] p_ll;
  logic [52:0] p_lh, p_hl;
  logic [51:0] p_hh;
  logic        m_sign, m_spec;
  logic signed [XEXP_W-1:0] m_exp;
  logic [63:0] m_word;

  always_comb begin
    se     = slope_bits[62:52];
    sf     = slope_bits[51:0];
    s_nan  = (se == 11'h7FF) && (sf != '0);
    s_inf  = (se == 11'h7FF) && (sf == '0);
    s_zero = (slope_bits[62:0] == '0);
    s_mag  = {se != '0, sf};
    s_exp  = (se == '0) ? -14'sd1074 : $signed({3'b000, se}) - 14'sd1075;
    x_nan  = x.spec && (x.word[51:0] != '0);
    x_inf  = x.spec && !x_nan;
    x_zero = !x.spec && (x.mag == '0);
    psign  = x.sign ^ slope_bits[63];
    spec   = 1'b1;
    if (x_nan) begin
      word = x.word | QUIET_BIT;
    end else if (s_nan) begin
      word = slope_bits | QUIET_BIT;
    end else if ((x_inf && s_zero) || (x_zero && s_inf)) begin
      word = DEFAULT_NAN;
    end else if (x_inf || s_inf) begin
      word = {psign, 11'h7FF, 52'd0};
    end else begin
      spec = 1'b0;
      word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll   <= x.mag[26:0]  * s_mag[26:0];
      p_lh   <= x.mag[26:0]  * s_mag[52:27];
      p_hl   <= x.mag[52:27] * s_mag[26:0];
      p_hh   <= x.mag[52:27] * s_mag[52:27];
      m_sign <= psign;
      m_exp  <= x.exp + s_exp;
      m_spec <= spec;
      m_word <= word;
    end
  end

  // stage 2: sum of partial products
  always_ff @(posedge clk) begin
    if (en) begin
      out_mag  <= 106'(p_ll) + (106'(p_lh) << 27) + (106'(p_hl) << 27) + (106'(p_hh) << 54);
      out_sign <= m_sign;
      out_exp  <= m_exp;
      out_spec <= m_spec;
      out_word <= m_word;
    end
  end

endmodule

`default_nettype wire

// ----- design/mrl_fadd.sv -----
`default_nettype none

module mrl_fadd (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [63:0]                       p_word,
  input  wire logic [63:0]                       c_word,
  output logic                                   out_sign,
  output logic [56:0]                            out_mag,
  output logic signed [mrl_pkg::XEXP_W-1:0]      out_exp,
  output logic                                   out_spec,
  output logic [63:0]                            out_word
);

  import mrl_pkg::*;

  // stage 1: order by magnitude, specials, exponent difference
  logic [10:0] pe, ce, be, sme, be_e, se_e, dfull;
  logic        p_nan, p_inf, c_nan, c_inf, p_big, eff_sub, cancel, spec;
  logic [63:0] big, sml, word;
  logic [5:0]  dcl;

  logic [52:0] a_bm, a_sm;
  logic [5:0]  a_d;
  logic        a_eff, a_sign, a_spec;
  logic signed [XEXP_W-1:0] a_exp;
  logic [63:0] a_word;

  always_comb begin
    pe      = p_word[62:52];
    ce      = c_word[62:52];
    p_nan   = (pe == 11'h7FF) && (p_word[51:0] != '0);
    p_inf   = (pe == 11'h7FF) && (p_word[51:0] == '0);
    c_nan   = (ce == 11'h7FF) && (c_word[51:0] != '0);
    c_inf   = (ce == 11'h7FF) && (c_word[51:0] == '0);
    p_big   = (p_word[62:0] >= c_word[62:0]);
    big     = p_big ? p_word : c_word;
    sml     = p_big ? c_word : p_word;
    be      = big[62:52];
    sme     = sml[62:52];
    be_e    = (be == '0) ? 11'd1 : be;
    se_e    = (sme == '0) ? 11'd1 : sme;
    dfull   = be_e - se_e;
    dcl     = (dfull > 11'd57) ? 6'd57 : dfull[5:0];
    eff_sub = p_word[63] ^ c_word[63];
    cancel  = eff_sub && (p_word[62:0] == c_word[62:0]);
    spec    = 1'b1;
    if (p_nan) begin
      word = p_word | QUIET_BIT;
    end else if (c_nan) begin
      word = c_word | QUIET_BIT;
    end else if (p_inf && c_inf && eff_sub) begin
      word = DEFAULT_NAN;
    end else if (p_inf) begin
      word = p_word;
    end else if (c_inf) begin
      word = c_word;
    end else begin
      spec = 1'b0;
      word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_bm   <= {be != '0, big[51:0]};
      a_sm   <= {sme != '0, sml[51:0]};
      a_d    <= dcl;
      a_eff  <= eff_sub;
      a_sign <= cancel ? 1'b0 : big[63];
      a_exp  <= $signed({3'b000, be_e}) - 14'sd1078;
      a_spec <= spec;
      a_word <= word;
    end
  end

  // stage 2: align the smaller operand, sticky folded into the lsb
  logic [111:0] ext;
  logic [55:0]  b_big, b_small;
  logic         b_eff, b_sign, b_spec;
  logic signed [XEXP_W-1:0] b_exp;
  logic [63:0]  b_word;

  always_comb begin
    ext = {a_sm, 3'b000, 56'd0} >> a_d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_big   <= {a_bm, 3'b000};
      b_small <= {ext[111:57], ext[56] | (|ext[55:0])};
      b_eff   <= a_eff;
      b_sign  <= a_sign;
      b_exp   <= a_exp;
      b_spec  <= a_spec;
      b_word  <= a_word;
    end
  end

  // stage 3: add or subtract magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      out_mag  <= b_eff ? ({1'b0, b_big} - {1'b0, b_small})
                        : ({1'b0, b_big} + {1'b0, b_small});
      out_sign <= b_sign;
      out_exp  <= b_exp;
      out_spec <= b_spec;
      out_word <= b_word;
    end
  end

endmodule

`default_nettype wire

// ----- design/mrl_table.sv -----
`default_nettype none

module mrl_table #(
  parameter int DEPTH = mrl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic               wr_en,
  input  wire logic [11:0]        wr_index,
  input  wire logic [31:0]        wr_word,
  input  wire logic signed [32:0] sample_val,
  input  wire logic [31:0]        map_base,
  input  wire logic [11:0]        last_entry,
  output logic      [31:0]        rd_word
);

  localparam int AW = $clog2(DEPTH);
  localparam logic signed [33:0] TOP_MAX = 34'(DEPTH - 1);

  logic [31:0] mem [DEPTH];

  logic signed [33:0] diff, lim, last_s, idx;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_ok;

  // offset from the first mapped value, clamped to the table bound
  always_comb begin
    diff    = $signed({sample_val[32], sample_val})
            - $signed({{2{map_base[31]}}, map_base});
    last_s  = $signed({22'd0, last_entry});
    lim     = (last_s > TOP_MAX) ? TOP_MAX : last_s;
    if (diff < 0) begin
      idx = '0;
    end else if (diff > lim) begin
      idx = lim;
    end else begin
      idx = diff;
    end
    rd_addr = idx[AW-1:0];
    wr_ok   = (32'(wr_index) < 32'(DEPTH));
    wr_addr = AW'(wr_index);
  end

  // one write port and one read port, loads and lookups in transaction order
  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_addr] <= wr_word;
    end
    if (en) begin
      rd_word <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
